/* rtl/core/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 64;

    localparam logic [0:0] KIND_HEADER  = 1'b0;
    localparam logic [0:0] KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [0:0]          event_kind;
        logic                fin_flag;
        logic [2:0]          reserved_bits;
        logic [3:0]          frame_opcode;
        logic                masked_flag;
        logic [LENGTH_W-1:0] payload_length;
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_end;
    } wsd_event_t;

endpackage

/* rtl/core/wsd_input_stage.sv */
// ----------------------------------------------------------------------------
// wsd_input_stage
// input register for the raw byte stream, frees up as the parser consumes
// ----------------------------------------------------------------------------
module wsd_input_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [wsd_pkg::BYTE_W-1:0] data_byte,
    input  logic                      step,
    output logic                      held_valid,
    output logic [wsd_pkg::BYTE_W-1:0] held_byte
);
    import wsd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              accept;

    assign in_stall = valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* rtl/core/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// frame header decode, length and key capture, payload unmasking
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [wsd_pkg::BYTE_W-1:0] held_byte,
    output logic                       emit,
    output wsd_pkg::wsd_event_t        event_out
);
    import wsd_pkg::*;

    typedef enum logic [1:0] {
        MODE_LEN7  = 2'd0,
        MODE_LEN16 = 2'd1,
        MODE_LEN64 = 2'd2
    } len_mode_t;

    localparam logic [6:0] CODE_LEN16 = 7'd126;
    localparam logic [6:0] CODE_LEN64 = 7'd127;
    localparam logic [3:0] END_LEN7   = 4'd1;
    localparam logic [3:0] END_LEN16  = 4'd3;
    localparam logic [3:0] END_LEN64  = 4'd9;
    localparam logic [3:0] KEY_BYTES  = 4'd4;
    localparam logic [3:0] IDX_FIRST  = 4'd0;
    localparam logic [3:0] IDX_LEN    = 4'd1;
    localparam logic [3:0] IDX_EXT    = 4'd2;

    logic                in_body_reg,  in_body_next;
    logic [3:0]          idx_reg,      idx_next;
    len_mode_t           mode_reg,     mode_next;
    logic [8:0]          hdr_reg,      hdr_next;
    logic [LENGTH_W-1:0] length_reg,   length_next;
    logic [BYTE_W-1:0]   key_reg  [4];
    logic [BYTE_W-1:0]   key_next [4];
    logic [1:0]          kpos_reg,     kpos_next;
    logic [LENGTH_W-1:0] remain_reg,   remain_next;

    logic                masked;
    logic [3:0]          len_end;
    logic [3:0]          last_idx;
    logic [3:0]          key_idx;
    logic [LENGTH_W-1:0] length_base;
    logic [BYTE_W-1:0]   pbyte;
    logic                frame_end;
    logic [0:0]          kind;

    always_comb
    begin
        in_body_next = in_body_reg;
        idx_next     = idx_reg;
        mode_next    = mode_reg;
        hdr_next     = hdr_reg;
        length_next  = length_reg;
        kpos_next    = kpos_reg;
        remain_next  = remain_reg;
        for (int i = 0; i < 4; i++)
        begin
            key_next[i] = key_reg[i];
        end
        emit        = 1'b0;
        kind        = KIND_HEADER;
        pbyte       = '0;
        frame_end   = 1'b0;
        masked      = hdr_reg[8];
        len_end     = END_LEN7;
        last_idx    = END_LEN7;
        key_idx     = '0;
        length_base = length_reg;

        if (in_body_reg)
        begin
            emit        = 1'b1;
            kind        = KIND_PAYLOAD;
            pbyte       = hdr_reg[8] ? (held_byte ^ key_reg[kpos_reg]) : held_byte;
            kpos_next   = kpos_reg + 2'd1;
            remain_next = remain_reg - LENGTH_W'(1);
            if (remain_reg == LENGTH_W'(1))
            begin
                frame_end    = 1'b1;
                in_body_next = 1'b0;
                idx_next     = IDX_FIRST;
            end
        end
        else if (idx_reg == IDX_FIRST)
        begin
            hdr_next    = {1'b0, held_byte[7], held_byte[6:4], held_byte[3:0]};
            mode_next   = MODE_LEN7;
            length_next = '0;
            idx_next    = IDX_LEN;
            for (int i = 0; i < 4; i++)
            begin
                key_next[i] = '0;
            end
        end
        else
        begin
            if (idx_reg == IDX_LEN)
            begin
                masked       = held_byte[7];
                hdr_next     = {held_byte[7], hdr_reg[7:0]};
                if (held_byte[6:0] == CODE_LEN64)
                begin
                    mode_next   = MODE_LEN64;
                    length_base = '0;
                end
                else if (held_byte[6:0] == CODE_LEN16)
                begin
                    mode_next   = MODE_LEN16;
                    length_base = '0;
                end
                else
                begin
                    mode_next   = MODE_LEN7;
                    length_base = LENGTH_W'(held_byte[6:0]);
                end
            end

            unique case (mode_next)
                MODE_LEN16: len_end = END_LEN16;
                MODE_LEN64: len_end = END_LEN64;
                default:    len_end = END_LEN7;
            endcase

            length_next = length_base;
            key_idx     = idx_reg - len_end - 4'd1;
            if (idx_reg >= IDX_EXT && idx_reg <= len_end)
            begin
                length_next = {length_base[LENGTH_W-BYTE_W-1:0], held_byte};
            end
            else if (idx_reg > len_end && masked && idx_reg <= len_end + KEY_BYTES)
            begin
                key_next[key_idx[1:0]] = held_byte;
            end

            last_idx = masked ? len_end + KEY_BYTES : len_end;
            if (idx_reg >= last_idx)
            begin
                emit     = 1'b1;
                idx_next = IDX_FIRST;
                if (length_next != '0)
                begin
                    in_body_next = 1'b1;
                    kpos_next    = '0;
                    remain_next  = length_next;
                end
                else
                begin
                    frame_end = 1'b1;
                end
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        event_out.event_kind     = kind;
        event_out.fin_flag       = hdr_next[7];
        event_out.reserved_bits  = hdr_next[6:4];
        event_out.frame_opcode   = hdr_next[3:0];
        event_out.masked_flag    = hdr_next[8];
        event_out.payload_length = length_next;
        event_out.payload_byte   = pbyte;
        event_out.frame_end      = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg <= 1'b0;
            idx_reg     <= IDX_FIRST;
            mode_reg    <= MODE_LEN7;
            hdr_reg     <= '0;
            length_reg  <= '0;
            kpos_reg    <= '0;
            remain_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            in_body_reg <= in_body_next;
            idx_reg     <= idx_next;
            mode_reg    <= mode_next;
            hdr_reg     <= hdr_next;
            length_reg  <= length_next;
            kpos_reg    <= kpos_next;
            remain_reg  <= remain_next;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

endmodule

/* rtl/core/wsd_output_stage.sv */
// ----------------------------------------------------------------------------
// wsd_output_stage
// result register holding one event beat until it is taken
// ----------------------------------------------------------------------------
module wsd_output_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  wsd_pkg::wsd_event_t event_in,
    input  logic                out_stall,
    output logic                out_valid,
    output wsd_pkg::wsd_event_t event_held
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    wsd_event_t event_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= event_in;
        end
    end

    assign out_valid  = valid_reg;
    assign event_held = event_reg;

endmodule

/* rtl/core/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// parses a websocket frame byte stream into header and unmasked payload beats
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   data_byte
//   out      source     out_valid / out_stall event_kind .. frame_end
//
// one input byte per cycle while in_stall is low; from input beat to result beat:
// input register, then header decode or key xor into the result register
// header bytes before the last one give no result beat
// reset clears all parser state, no clearing pass
// in_stall rises only while a byte is held and the result register is
// full, stalled and the held byte would give a result
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [wsd_pkg::BYTE_W-1:0]   data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         event_kind,
    output logic                         fin_flag,
    output logic [2:0]                   reserved_bits,
    output logic [3:0]                   frame_opcode,
    output logic                         masked_flag,
    output logic [wsd_pkg::LENGTH_W-1:0] payload_length,
    output logic [wsd_pkg::BYTE_W-1:0]   payload_byte,
    output logic                         frame_end
);
    import wsd_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              step;
    logic              emit;
    wsd_event_t        event_new;
    wsd_event_t        event_held;

    assign step = held_valid && (!emit || !out_valid || !out_stall);

    wsd_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .step       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .held_byte (held_byte),
        .emit      (emit),
        .event_out (event_new)
    );

    wsd_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && emit),
        .event_in   (event_new),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .event_held (event_held)
    );

    assign event_kind     = event_held.event_kind;
    assign fin_flag       = event_held.fin_flag;
    assign reserved_bits  = event_held.reserved_bits;
    assign frame_opcode   = event_held.frame_opcode;
    assign masked_flag    = event_held.masked_flag;
    assign payload_length = event_held.payload_length;
    assign payload_byte   = event_held.payload_byte;
    assign frame_end      = event_held.frame_end;

    a_stall_needs_blocked_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled while result register can drain");

    a_header_end_on_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == KIND_HEADER))
            |-> (frame_end == (payload_length == '0)) && (payload_byte == '0)
    ) else $error("header beat end flag does not match length");

    a_payload_needs_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == KIND_PAYLOAD)) |-> (payload_length != '0)
    ) else $error("payload beat in an empty frame");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the websocket frame deframer: a short table of
// frames with a few header beats typed in, then random frames of every length
// encoding, masked and unmasked, checked beat by beat against a local parser
// under several sender idle and receiver stall mixes
// ----------------------------------------------------------------------------
module tb_top;

    import wsd_pkg::*;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_mode_t;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 1350;
    localparam int MAX_SHOWN     = 10;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam wsd_event_t NO_BEAT         = '0;
    localparam wsd_event_t EV_PING_EMPTY   =
        '{KIND_HEADER, 1'b1, 3'd0, 4'h9, 1'b0, 64'd0, 8'h00, 1'b1};
    localparam wsd_event_t EV_MASKED_SHORT =
        '{KIND_HEADER, 1'b1, 3'd7, 4'h2, 1'b1, 64'd2, 8'h00, 1'b0};
    localparam wsd_event_t EV_EXT16_EMPTY  =
        '{KIND_HEADER, 1'b0, 3'd0, 4'hf, 1'b0, 64'd0, 8'h00, 1'b1};
    localparam wsd_event_t EV_EXT64_ONE    =
        '{KIND_HEADER, 1'b0, 3'd7, 4'h0, 1'b0, 64'd1, 8'h00, 1'b0};

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       gives;
        wsd_event_t beat;
    } stim_row_t;

    stim_row_t stim_table [DIRECTED_ROWS] = '{
        // empty ping frame
        '{8'h89, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b1, EV_PING_EMPTY},
        // masked short frame, all reserved bits set
        '{8'hf2, TYPED, 1'b0, NO_BEAT},
        '{8'h82, TYPED, 1'b0, NO_BEAT},
        '{8'hff, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'ha5, TYPED, 1'b0, NO_BEAT},
        '{8'h5a, TYPED, 1'b1, EV_MASKED_SHORT},
        '{8'h00, PREDICTED, 1'b0, NO_BEAT},
        '{8'hff, PREDICTED, 1'b0, NO_BEAT},
        // 16-bit length code with zero extension
        '{8'h0f, TYPED, 1'b0, NO_BEAT},
        '{8'h7e, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b1, EV_EXT16_EMPTY},
        // 64-bit length code, one unmasked byte
        '{8'h70, TYPED, 1'b0, NO_BEAT},
        '{8'h7f, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h00, TYPED, 1'b0, NO_BEAT},
        '{8'h01, TYPED, 1'b1, EV_EXT64_ONE},
        '{8'hc3, PREDICTED, 1'b0, NO_BEAT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        event_kind;
    logic        fin_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;

    // local parser state
    logic        in_frame_body = 1'b0;
    logic [3:0]  hdr_pos = 4'd0;
    len_mode_t   len_mode = LEN_SHORT;
    logic [8:0]  hdr_flags = 9'd0;
    logic [63:0] frame_len = 64'd0;
    logic [7:0]  key_bytes [4] = '{default: 8'h00};
    logic [1:0]  key_idx = 2'd0;
    logic [63:0] body_count = 64'd0;

    wsd_event_t  pending_events [$];
    wsd_event_t  seen_beat;
    wsd_event_t  want_beat;

    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    int          bytes_in = 0;
    int          beats_out = 0;
    int          header_beats = 0;
    int          masked_frames = 0;
    int          empty_frames = 0;
    int          mismatches = 0;

    websocket_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .fin_flag       (fin_flag),
        .reserved_bits  (reserved_bits),
        .frame_opcode   (frame_opcode),
        .masked_flag    (masked_flag),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    function automatic wsd_event_t frame_beat(input logic [0:0] kind, input logic [7:0] pb,
                                              input logic last);
        wsd_event_t ev;
        ev.event_kind     = kind;
        ev.fin_flag       = hdr_flags[7];
        ev.reserved_bits  = hdr_flags[6:4];
        ev.frame_opcode   = hdr_flags[3:0];
        ev.masked_flag    = hdr_flags[8];
        ev.payload_length = frame_len;
        ev.payload_byte   = pb;
        ev.frame_end      = last;
        return ev;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output wsd_event_t ev);
        logic [7:0] pb;
        logic [3:0] len_last;
        logic [3:0] hdr_last;
        logic [3:0] key_slot;
        logic       keyed;
        ev = NO_BEAT;
        if (in_frame_body)
        begin
            pb = hdr_flags[8] ? (b ^ key_bytes[key_idx]) : b;
            key_idx = key_idx + 2'd1;
            body_count = body_count + 64'd1;
            ev = frame_beat(KIND_PAYLOAD, pb, body_count == frame_len);
            if (body_count == frame_len)
            begin
                in_frame_body = 1'b0;
                hdr_pos = 4'd0;
            end
            return 1'b1;
        end
        if (hdr_pos == 4'd0)
        begin
            // fin, reserved bits and opcode sit where the first byte has them
            hdr_flags = {1'b0, b};
            key_bytes = '{default: 8'h00};
            len_mode = LEN_SHORT;
            frame_len = 64'd0;
            hdr_pos = 4'd1;
            return 1'b0;
        end
        if (hdr_pos == 4'd1)
        begin
            hdr_flags[8] = b[7];
            frame_len = 64'd0;
            if (b[6:0] == LEN_CODE_64)
                len_mode = LEN_EXT64;
            else if (b[6:0] == LEN_CODE_16)
                len_mode = LEN_EXT16;
            else
            begin
                len_mode = LEN_SHORT;
                frame_len = {57'd0, b[6:0]};
            end
        end
        keyed = hdr_flags[8];
        len_last = (len_mode == LEN_EXT16) ? 4'd3 : (len_mode == LEN_EXT64) ? 4'd9 : 4'd1;
        if (hdr_pos >= 4'd2 && hdr_pos <= len_last)
            frame_len = {frame_len[55:0], b};
        else if (hdr_pos > len_last && keyed && hdr_pos <= len_last + 4'd4)
        begin
            key_slot = hdr_pos - len_last - 4'd1;
            key_bytes[key_slot[1:0]] = b;
        end
        hdr_last = keyed ? len_last + 4'd4 : len_last;
        if (hdr_pos >= hdr_last)
        begin
            ev = frame_beat(KIND_HEADER, 8'h00, frame_len == 64'd0);
            if (frame_len != 64'd0)
            begin
                in_frame_body = 1'b1;
                body_count = 64'd0;
                key_idx = 2'd0;
            end
            hdr_pos = 4'd0;
            return 1'b1;
        end
        hdr_pos = hdr_pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic typed, input logic typed_gives,
                             input wsd_event_t typed_beat);
        bit         taken;
        bit         gives;
        wsd_event_t ev;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        bytes_in++;
        gives = deframe_byte(b, ev);
        if (typed)
        begin
            gives = typed_gives;
            ev = typed_beat;
        end
        if (gives)
        begin
            pending_events.push_back(ev);
            if (ev.event_kind == KIND_HEADER)
            begin
                header_beats++;
                if (ev.masked_flag)
                    masked_frames++;
                if (ev.frame_end)
                    empty_frames++;
            end
        end
    endtask

    task automatic send_frame(input logic [7:0] first, input logic masked, input len_mode_t mode,
                              input logic [63:0] len, input int body_bytes);
        logic [6:0] code;
        code = (mode == LEN_EXT16) ? LEN_CODE_16 : (mode == LEN_EXT64) ? LEN_CODE_64 : len[6:0];
        feed_byte(first, PREDICTED, 1'b0, NO_BEAT);
        feed_byte({masked, code}, PREDICTED, 1'b0, NO_BEAT);
        if (mode == LEN_EXT16)
        begin
            feed_byte(len[15:8], PREDICTED, 1'b0, NO_BEAT);
            feed_byte(len[7:0], PREDICTED, 1'b0, NO_BEAT);
        end
        else if (mode == LEN_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                feed_byte(len[i*8 +: 8], PREDICTED, 1'b0, NO_BEAT);
        end
        if (masked)
        begin
            for (int i = 0; i < 4; i++)
                feed_byte(8'($urandom_range(255)), PREDICTED, 1'b0, NO_BEAT);
        end
        for (int i = 0; i < body_bytes; i++)
            feed_byte(8'($urandom_range(255)), PREDICTED, 1'b0, NO_BEAT);
    endtask

    function automatic string beat_text(input wsd_event_t ev);
        return $sformatf("kind %0d fin %0d rsv %0d op %0h mask %0d len %h byte %02h end %0d",
                         ev.event_kind, ev.fin_flag, ev.reserved_bits, ev.frame_opcode,
                         ev.masked_flag, ev.payload_length, ev.payload_byte, ev.frame_end);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat = {event_kind, fin_flag, reserved_bits, frame_opcode, masked_flag,
                         payload_length, payload_byte, frame_end};
            beats_out++;
            if (pending_events.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected beat at %0t: %s", $time, beat_text(seen_beat));
                mismatches++;
            end
            else
            begin
                want_beat = pending_events.pop_front();
                if (seen_beat !== want_beat)
                begin
                    if (mismatches < MAX_SHOWN)
                    begin
                        $display("beat mismatch at %0t", $time);
                        $display("  expected %s", beat_text(want_beat));
                        $display("  actual   %s", beat_text(seen_beat));
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("websocket_frame_deframer verification failed");
        $finish;
    end

    initial
    begin
        int          phase;
        int unsigned sel;
        logic [63:0] len;
        len_mode_t   mode;
        int          guard;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
            feed_byte(stim_table[i].data, stim_table[i].typed, stim_table[i].gives,
                      stim_table[i].beat);

        while (bytes_in < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            phase = ((bytes_in - DIRECTED_ROWS) * 4) / RANDOM_BYTES;
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 48; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                mode = LEN_SHORT;
                len = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                               : 64'($urandom_range(12));
            end
            else if (sel < 80)
            begin
                mode = LEN_EXT16;
                len = ($urandom_range(9) == 0) ? 64'($urandom_range(300))
                                               : 64'($urandom_range(20));
            end
            else
            begin
                mode = LEN_EXT64;
                len = 64'($urandom_range(20));
            end
            send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), mode, len, int'(len));
        end

        // all-ones 64-bit length, body never completes
        send_frame(8'h82, 1'b1, LEN_EXT64, '1, 24);
        in_valid <= 1'b0;

        guard = 0;
        while (pending_events.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);

        if (pending_events.size() != 0)
        begin
            $display("%0d expected beats never arrived", pending_events.size());
            mismatches++;
        end

        $display("run: %0d bytes in, %0d result beats, %0d headers (%0d masked, %0d empty)",
                 bytes_in, beats_out, header_beats, masked_frames, empty_frames);
        $display("     %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("websocket_frame_deframer verification clean");
        else
            $display("websocket_frame_deframer verification failed");
        $finish;
    end

endmodule
